>>> sv/packet_deframer_sum_checksum_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer core
// Clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_SUM_CHECKSUM_CORE_ASSERT_SVH
`define PACKET_DEFRAMER_SUM_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication.
`define PDSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pdsc_pkg.sv
// ----------------------------------------------------------------------------
// pdsc_pkg
// Shared types and codes of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdsc_pkg;

	// Frame phase, one-hot
	typedef enum logic [5:0] {
		PH_HUNT1 = 6'b000001,
		PH_HUNT2 = 6'b000010,
		PH_CMD   = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_BODY  = 6'b010000,
		PH_SUM   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BODY   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_BADSUM = 2'd2
	} kind_t;

	localparam logic CFG_SYNC_FIRST  = 1'b0;
	localparam logic CFG_SYNC_SECOND = 1'b1;

	// Byte request from the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} byte_req_t;

	// Configuration write request
	typedef struct packed {
		logic       valid;
		logic       index;
		logic [7:0] data;
	} cfg_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] body_index;
		logic [7:0] body_length;
	} result_t;

endpackage

`default_nettype wire

>>> sv/pdsc_in_stage.sv
// ----------------------------------------------------------------------------
// pdsc_in_stage
// Input register: captures one received byte per request and holds it
// until the frame tracker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsc_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              advance,
	output pdsc_pkg::byte_req_t    req
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;

	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

	assign req.valid   = valid_s1;
	assign req.rx_byte = byte_s1;

endmodule

`default_nettype wire

>>> sv/pdsc_tracker.sv
// ----------------------------------------------------------------------------
// pdsc_tracker
// Frame phase machine with running checksum, held command and length,
// body counter and the two sync registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsc_tracker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pdsc_pkg::cfg_req_t  cfg,
	input  wire pdsc_pkg::byte_req_t req,
	input  wire logic                advance,
	output logic                     res_valid,
	output pdsc_pkg::result_t        res
);

	pdsc_pkg::phase_t phase_q, phase_d;
	logic [7:0] sync_first_q, sync_second_q;
	logic [7:0] sum_q, sum_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] len_q, len_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] b;
	logic [7:0] sum_add;
	logic [7:0] seen_inc;
	logic       emit;

	assign b        = req.rx_byte;
	assign sum_add  = sum_q + b;
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		seen_d  = seen_q;
		emit    = 1'b0;
		res.kind        = pdsc_pkg::KIND_BODY;
		res.data_byte   = b;
		res.body_index  = seen_q;
		res.body_length = len_q;
		unique case (phase_q)
			pdsc_pkg::PH_HUNT2: begin
				if (b == sync_second_q) begin
					sum_d   = sum_add;
					phase_d = pdsc_pkg::PH_CMD;
				end else begin
					// drop; this byte is not retried as sync one
					phase_d = pdsc_pkg::PH_HUNT1;
				end
			end
			pdsc_pkg::PH_CMD: begin
				cmd_d   = b;
				sum_d   = sum_add;
				phase_d = pdsc_pkg::PH_LEN;
			end
			pdsc_pkg::PH_LEN: begin
				len_d   = b;
				sum_d   = sum_add;
				seen_d  = '0;
				phase_d = (b == 8'd0) ? pdsc_pkg::PH_SUM : pdsc_pkg::PH_BODY;
			end
			pdsc_pkg::PH_BODY: begin
				emit   = 1'b1;
				sum_d  = sum_add;
				seen_d = seen_inc;
				if (seen_inc == len_q) begin
					phase_d = pdsc_pkg::PH_SUM;
				end
			end
			pdsc_pkg::PH_SUM: begin
				emit           = 1'b1;
				res.kind       = (b == sum_q) ? pdsc_pkg::KIND_ACCEPT : pdsc_pkg::KIND_BADSUM;
				res.data_byte  = cmd_q;
				res.body_index = '0;
				sum_d          = '0;
				seen_d         = '0;
				phase_d        = pdsc_pkg::PH_HUNT1;
			end
			default: begin
				// hunt for sync one; the sum restarts from the sync byte
				if (b == sync_first_q) begin
					sum_d   = b;
					phase_d = pdsc_pkg::PH_HUNT2;
				end else begin
					sum_d   = '0;
					phase_d = pdsc_pkg::PH_HUNT1;
				end
			end
		endcase
	end

	assign res_valid = req.valid && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdsc_pkg::PH_HUNT1;
			sum_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			seen_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= '0;
			sync_second_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pdsc_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg.data;
				pdsc_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/pdsc_out_stage.sv
// ----------------------------------------------------------------------------
// pdsc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pdsc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire pdsc_pkg::result_t res,
	output logic                   free,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output pdsc_pkg::result_t      res_out
);

	logic              out_valid_q;
	pdsc_pkg::result_t res_q;

	// room when empty or when the held result leaves this cycle
	assign free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign res_out   = res_q;

endmodule

`default_nettype wire

>>> sv/packet_deframer_sum_checksum_core.sv
// One received byte is taken per request and the block keeps up with a
// byte every cycle. A byte passes an input register, then the frame phase
// machine and 8-bit checksum add, then a result register, from which a body
// byte or a verdict is offered at the output. Bytes that give no result
// (sync, command, length) retire without using the result register; a held
// result stalls the input only when the next byte needs it.
// ----------------------------------------------------------------------------
// packet_deframer_sum_checksum_core
// Two-byte sync, length-prefixed frame deframer with additive checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_deframer_sum_checksum_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      result_kind,
	output logic [7:0]      data_byte,
	output logic [7:0]      body_index,
	output logic [7:0]      body_length,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	pdsc_pkg::byte_req_t req;
	pdsc_pkg::cfg_req_t  cfg;
	pdsc_pkg::result_t   res;
	pdsc_pkg::result_t   res_out;
	logic                res_valid;
	logic                free;
	logic                advance;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// retire the held byte unless it needs the result register and that is full
	assign advance = req.valid && (!res_valid || free);

	pdsc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.req      (req)
	);

	pdsc_tracker u_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	pdsc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid && advance),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign result_kind = res_out.kind;
	assign data_byte   = res_out.data_byte;
	assign body_index  = res_out.body_index;
	assign body_length = res_out.body_length;

endmodule

`default_nettype wire

>>> sv/pdsc_checker.sv
// ----------------------------------------------------------------------------
// pdsc_checker
// Port-level checks of the deframer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_deframer_sum_checksum_core_assert.svh"

module pdsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] rx_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] result_kind,
	input wire logic [7:0] data_byte,
	input wire logic [7:0] body_index,
	input wire logic [7:0] body_length
);

	`PDSC_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(rx_byte),
		"stalled request changed")

	`PDSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(result_kind) && $stable(data_byte)
			&& $stable(body_index) && $stable(body_length),
		"stalled result changed")

	`PDSC_ASSERT_NOW(a_kind_legal, out_valid,
		result_kind == pdsc_pkg::KIND_BODY || result_kind == pdsc_pkg::KIND_ACCEPT
			|| result_kind == pdsc_pkg::KIND_BADSUM,
		"illegal result kind")

	`PDSC_ASSERT_NOW(a_body_in_range, out_valid && result_kind == pdsc_pkg::KIND_BODY,
		body_index < body_length,
		"body index beyond declared length")

	`PDSC_ASSERT_NOW(a_verdict_index, out_valid && result_kind != pdsc_pkg::KIND_BODY,
		body_index == 8'd0,
		"verdict carries nonzero body index")

endmodule

bind packet_deframer_sum_checksum_core pdsc_checker u_pdsc_checker (.*);

`default_nettype wire
